/* rtl/core/ggo_pkg.sv */
// Shared types, codes and constants of the gene operator unit.
package ggo_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GENE_W    = 20;
  localparam int IDX_W     = 12;
  localparam int RAND_W    = 16;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 19;

  typedef enum logic [1:0] {
    OP_MATE        = 2'd0,
    OP_MUT_RESET   = 2'd1,
    OP_MUT_PERTURB = 2'd2,
    OP_DIFF        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MATE_SINGLE  = 2'd0,
    MATE_UNIFORM = 2'd1,
    MATE_BLEND   = 2'd2,
    MATE_RANDOM  = 2'd3
  } mate_mode_t;

  localparam logic [1:0] BND_NONE  = 2'd0;
  localparam logic [1:0] BND_CLAMP = 2'd1;
  localparam logic [1:0] BND_WRAP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MATE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_PARAM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTATE_PROB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTATE_AMOUNT = 3'd4;

  typedef struct packed {
    mate_mode_t  mate_mode;
    logic [1:0]  bounds_mode;
    logic [16:0] mate_param;
    logic [16:0] mutate_prob;
    logic [18:0] mutate_amount;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic is_diff;
    logic last;
  } pass_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] difference_sum;
    logic [SUM_W-1:0] generation;
  } pass_res_t;

endpackage

/* rtl/core/genetic_gene_operator_unit.sv */
// Top level of the gene operator unit: input register, datapath, result register.
// One gene item is accepted per cycle while in_ready is high. Its result reaches the output
// through both registers: the item is held in the input register, worked through the
// gene datapath and pass-state logic, and lands in the result register.
// in_ready follows out_ready combinationally, so both registers stay full under a
// steady stream. The configuration port is always ready; write it only while no item
// is in flight. difference_sum carries the running gap sum on difference items,
// complete on the one marked last, and is zero on the others.
module genetic_gene_operator_unit
  import ggo_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic signed [GENE_W-1:0] in_own_gene,
  input  logic signed [GENE_W-1:0] in_other_gene,
  input  logic [IDX_W-1:0]         in_gene_index,
  input  logic [IDX_W-1:0]         in_crossover_point,
  input  logic [RAND_W-1:0]        in_random_select,
  input  logic [RAND_W-1:0]        in_random_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [GENE_W-1:0] out_new_gene,
  output logic [SUM_W-1:0]         out_difference_sum,
  output logic [SUM_W-1:0]         out_generation,
  output logic                     out_last_out
);

  cfg_t cfg;

  logic                     s1_valid_r;
  op_t                      s1_op_r;
  logic signed [GENE_W-1:0] s1_own_r;
  logic signed [GENE_W-1:0] s1_other_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic [IDX_W-1:0]         s1_cpt_r;
  logic [RAND_W-1:0]        s1_rsel_r;
  logic [RAND_W-1:0]        s1_rval_r;
  logic                     s1_last_r;

  logic                     out_valid_r;
  logic signed [GENE_W-1:0] out_gene_r;
  logic [SUM_W-1:0]         out_dsum_r;
  logic [SUM_W-1:0]         out_gen_r;
  logic                     out_last_r;

  logic                     adv;
  logic                     s1_fire;
  logic                     in_fire;
  logic signed [GENE_W-1:0] alu_gene;
  pass_req_t                preq;
  pass_res_t                pres;
  logic [SUM_W-1:0]         gen_count;

  ggo_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign adv      = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= op_t'(in_opcode);
      s1_own_r   <= in_own_gene;
      s1_other_r <= in_other_gene;
      s1_idx_r   <= in_gene_index;
      s1_cpt_r   <= in_crossover_point;
      s1_rsel_r  <= in_random_select;
      s1_rval_r  <= in_random_value;
      s1_last_r  <= in_last;
    end
  end

  ggo_gene_alu u_alu (
    .cfg             (cfg),
    .opcode          (s1_op_r),
    .own_gene        (s1_own_r),
    .other_gene      (s1_other_r),
    .gene_index      (s1_idx_r),
    .crossover_point (s1_cpt_r),
    .random_select   (s1_rsel_r),
    .random_value    (s1_rval_r),
    .new_gene        (alu_gene)
  );

  assign preq.fire    = s1_fire;
  assign preq.is_diff = (s1_op_r == OP_DIFF);
  assign preq.last    = s1_last_r;

  ggo_pass_state u_pass (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (preq),
    .own_gene   (s1_own_r),
    .other_gene (s1_other_r),
    .res        (pres),
    .gen_count  (gen_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_gene_r <= alu_gene;
      out_dsum_r <= pres.difference_sum;
      out_gen_r  <= pres.generation;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_new_gene       = out_gene_r;
  assign out_difference_sum = out_dsum_r;
  assign out_generation     = out_gen_r;
  assign out_last_out       = out_last_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with a free stage");

  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r && s1_op_r != OP_DIFF) |=>
      (gen_count == $past(gen_count) + 32'd1))
    else $error("generation count missed a pass");

  a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_fire && s1_last_r && s1_op_r != OP_DIFF) |=> $stable(gen_count))
    else $error("generation count moved without a pass end");

  a_dsum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r != OP_DIFF) |=> (out_difference_sum == '0))
    else $error("difference sum on a mate or mutate beat");

endmodule

/* rtl/core/ggo_cfg_regs.sv */
// Configuration register file of the gene operator unit.
module ggo_cfg_regs
  import ggo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mate_mode     <= MATE_SINGLE;
      cfg_r.bounds_mode   <= BND_WRAP;
      cfg_r.mate_param    <= 17'd32768;
      cfg_r.mutate_prob   <= 17'd0;
      cfg_r.mutate_amount <= 19'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MATE_MODE:     cfg_r.mate_mode     <= mate_mode_t'(cfg_data[1:0]);
        CFG_BOUNDS_MODE:   cfg_r.bounds_mode   <= cfg_data[1:0];
        CFG_MATE_PARAM:    cfg_r.mate_param    <= cfg_data[16:0];
        CFG_MUTATE_PROB:   cfg_r.mutate_prob   <= cfg_data[16:0];
        CFG_MUTATE_AMOUNT: cfg_r.mutate_amount <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/ggo_gene_alu.sv */
// Combinational gene datapath: mate, mutate, bounding and saturation.
module ggo_gene_alu
  import ggo_pkg::*;
(
  input  cfg_t                     cfg,
  input  op_t                      opcode,
  input  logic signed [GENE_W-1:0] own_gene,
  input  logic signed [GENE_W-1:0] other_gene,
  input  logic [IDX_W-1:0]         gene_index,
  input  logic [IDX_W-1:0]         crossover_point,
  input  logic [RAND_W-1:0]        random_select,
  input  logic [RAND_W-1:0]        random_value,
  output logic signed [GENE_W-1:0] new_gene
);

  localparam logic [16:0]        ONE17 = 17'(1 << FRAC_BITS);
  localparam logic signed [23:0] ONE24 = 24'sd65536;
  localparam logic signed [23:0] GMAX  = 24'sd524287;
  localparam logic signed [23:0] GMIN  = -24'sd524288;

  function automatic logic signed [GENE_W-1:0] bound_gene(input logic [1:0] mode,
                                                          input logic signed [23:0] x);
    logic signed [23:0] y;
    logic signed [23:0] xm1;
    y   = x;
    xm1 = x - 24'sd1;
    unique case (mode)
      BND_CLAMP: begin
        if (x > ONE24) begin
          y = ONE24;
        end else if (x < 24'sd0) begin
          y = 24'sd0;
        end
      end
      BND_WRAP: begin
        if (x > ONE24) begin
          y = $signed({8'd0, xm1[FRAC_BITS-1:0]}) + 24'sd1;
        end else if (x < 24'sd0) begin
          y = $signed({8'd0, x[FRAC_BITS-1:0]});
        end
      end
      default: ;
    endcase
    if (y > GMAX) begin
      y = GMAX;
    end else if (y < GMIN) begin
      y = GMIN;
    end
    return y[GENE_W-1:0];
  endfunction

  logic [16:0]        w17;
  logic [16:0]        iw17;
  logic signed [38:0] blend_sum;
  logic signed [38:0] blend_rnd;
  logic signed [20:0] gdiff;
  logic signed [37:0] rb_prod;
  logic signed [37:0] rb_rnd;
  logic [35:0]        pt_prod;
  logic [35:0]        pt_rnd;
  logic signed [23:0] own24;
  logic signed [23:0] other24;
  logic               mut_hit;
  logic signed [23:0] pre;

  always_comb begin
    own24   = {{4{own_gene[GENE_W-1]}}, own_gene};
    other24 = {{4{other_gene[GENE_W-1]}}, other_gene};

    w17       = (cfg.mate_param > ONE17) ? ONE17 : cfg.mate_param;
    iw17      = ONE17 - w17;
    blend_sum = own_gene * $signed({1'b0, iw17}) + other_gene * $signed({1'b0, w17});
    blend_rnd = blend_sum + 39'sd32768;

    gdiff   = other_gene - own_gene;
    rb_prod = gdiff * $signed({1'b0, random_value});
    rb_rnd  = rb_prod + 38'sd32768;

    pt_prod = {cfg.mutate_amount, 1'b0} * random_value;
    pt_rnd  = pt_prod + 36'd32768;

    mut_hit = {1'b0, random_select} < cfg.mutate_prob;

    pre = own24;
    unique case (opcode)
      OP_MATE: begin
        unique case (cfg.mate_mode)
          MATE_SINGLE:  pre = (gene_index >= crossover_point) ? other24 : own24;
          MATE_UNIFORM: pre = ({1'b0, random_select} > cfg.mate_param) ? other24 : own24;
          MATE_BLEND:   pre = {blend_rnd[38], blend_rnd[38:16]};
          MATE_RANDOM:  pre = own24 + {{2{rb_rnd[37]}}, rb_rnd[37:16]};
        endcase
      end
      OP_MUT_RESET: begin
        if (mut_hit) begin
          pre = {8'd0, random_value};
        end
      end
      OP_MUT_PERTURB: begin
        if (mut_hit) begin
          pre = own24 - $signed({5'd0, cfg.mutate_amount}) + $signed({4'd0, pt_rnd[35:16]});
        end
      end
      OP_DIFF: pre = own24;
    endcase

    if (opcode == OP_DIFF) begin
      new_gene = own_gene;
    end else begin
      new_gene = bound_gene(cfg.bounds_mode, pre);
    end
  end

endmodule

/* rtl/core/ggo_pass_state.sv */
// Difference accumulator and generation counter of a genome pass.
module ggo_pass_state
  import ggo_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pass_req_t                req,
  input  logic signed [GENE_W-1:0] own_gene,
  input  logic signed [GENE_W-1:0] other_gene,
  output pass_res_t                res,
  output logic [SUM_W-1:0]         gen_count
);

  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [SUM_W-1:0]   gen_r, gen_nxt;
  logic signed [20:0] gap_s;
  logic [20:0]        gap;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic               gen_inc;

  always_comb begin
    gap_s    = other_gene - own_gene;
    gap      = gap_s[20] ? 21'(-gap_s) : 21'(gap_s);
    sum_wide = {1'b0, acc_r} + {12'd0, gap};
    sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    gen_inc  = !req.is_diff && req.last;

    res.difference_sum = req.is_diff ? sum_sat : '0;
    res.generation     = gen_r + {31'd0, gen_inc};

    acc_nxt = acc_r;
    gen_nxt = gen_r;
    if (req.fire) begin
      if (req.is_diff) begin
        acc_nxt = req.last ? '0 : sum_sat;
      end
      gen_nxt = res.generation;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      gen_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      gen_r <= gen_nxt;
    end
  end

  assign gen_count = gen_r;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for the gene operator unit: directed script, random passes, predictor.
module testbench;
  import ggo_pkg::*;

  localparam longint GENE_TOP     = (longint'(1) <<< (GENE_W - 1)) - 1;
  localparam longint GENE_BOTTOM  = -(longint'(1) <<< (GENE_W - 1));
  localparam longint GENE_ONE     = longint'(1) <<< FRAC_BITS;
  localparam longint SUM_CEIL     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [1:0] BND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int PASS_ITEMS       = 160;

  typedef struct {
    op_t                     op;
    logic signed [GENE_W-1:0] own;
    logic signed [GENE_W-1:0] other;
    logic [IDX_W-1:0]        idx;
    logic [IDX_W-1:0]        cpt;
    logic [RAND_W-1:0]       rsel;
    logic [RAND_W-1:0]       rval;
    logic                    last;
  } gene_beat_t;

  typedef struct {
    logic signed [GENE_W-1:0] gene;
    logic [SUM_W-1:0]        dsum;
    logic [SUM_W-1:0]        gen;
    logic                    last;
  } gene_result_t;

  typedef enum logic {ROW_GENE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    gene_beat_t             beat;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DAT_W-1:0]   reg_value;
    bit                     pinned;
    gene_result_t           want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic signed [GENE_W-1:0] in_own_gene = '0;
  logic signed [GENE_W-1:0] in_other_gene = '0;
  logic [IDX_W-1:0] in_gene_index = '0;
  logic [IDX_W-1:0] in_crossover_point = '0;
  logic [RAND_W-1:0] in_random_select = '0;
  logic [RAND_W-1:0] in_random_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [GENE_W-1:0] out_new_gene;
  logic [SUM_W-1:0] out_difference_sum;
  logic [SUM_W-1:0] out_generation;
  logic out_last_out;

  logic pin_on = 1'b0;
  logic signed [GENE_W-1:0] pin_gene = '0;
  logic [SUM_W-1:0] pin_sum = '0;
  logic [SUM_W-1:0] pin_gen = '0;

  mate_mode_t sh_mate_mode = MATE_SINGLE;
  logic [1:0] sh_bounds = BND_WRAP;
  logic [16:0] sh_mate_param = 17'd32768;
  logic [16:0] sh_mutate_prob = '0;
  logic [18:0] sh_mutate_amount = '0;
  logic [SUM_W-1:0] gap_sum = '0;
  logic [SUM_W-1:0] pass_count = '0;

  gene_result_t pending_results[$];
  script_row_t script[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  genetic_gene_operator_unit uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

  function automatic longint round16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint q16_as_gene(longint v);
    return (v <<< FRAC_BITS) >>> 16;
  endfunction

  function automatic longint clip_gene(longint x);
    longint r;
    if (sh_bounds == BND_CLAMP) begin
      if (x > GENE_ONE) x = GENE_ONE;
      if (x < 0) x = 0;
    end else if (sh_bounds == BND_WRAP) begin
      if (x > GENE_ONE) begin
        x = ((x - 1) % GENE_ONE) + 1;
      end else if (x < 0) begin
        r = (-x) % GENE_ONE;
        x = (r != 0) ? GENE_ONE - r : 0;
      end
    end
    if (x > GENE_TOP) x = GENE_TOP;
    if (x < GENE_BOTTOM) x = GENE_BOTTOM;
    return x;
  endfunction

  function automatic gene_result_t apply_gene_op(gene_beat_t b);
    gene_result_t r;
    longint own, other, x, gap, acc, w, amt, rsel, rval;
    own = b.own;
    other = b.other;
    rsel = longint'(b.rsel);
    rval = longint'(b.rval);
    x = own;
    r.dsum = '0;
    if (b.op == OP_DIFF) begin
      gap = other - own;
      if (gap < 0) gap = -gap;
      acc = longint'(gap_sum) + gap;
      if (acc > SUM_CEIL) acc = SUM_CEIL;
      gap_sum = acc[SUM_W-1:0];
      r.dsum = gap_sum;
      if (b.last) gap_sum = '0;
    end else begin
      if (b.op == OP_MATE) begin
        case (sh_mate_mode)
          MATE_SINGLE:  x = (b.idx >= b.cpt) ? other : own;
          MATE_UNIFORM: x = (rsel > longint'(sh_mate_param)) ? other : own;
          MATE_BLEND: begin
            w = (sh_mate_param > 17'd65536) ? 65536 : longint'(sh_mate_param);
            x = round16(own * (65536 - w) + other * w);
          end
          default:      x = own + round16((other - own) * rval);
        endcase
      end else if (rsel < longint'(sh_mutate_prob)) begin
        if (b.op == OP_MUT_RESET) begin
          x = q16_as_gene(rval);
        end else begin
          amt = q16_as_gene(longint'(sh_mutate_amount));
          x = own - amt + round16(2 * amt * rval);
        end
      end
      x = clip_gene(x);
      if (b.last) pass_count = pass_count + 1'b1;
    end
    r.gene = x[GENE_W-1:0];
    r.gen = pass_count;
    r.last = b.last;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    gene_beat_t b;
    gene_result_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected beat, new_gene", out_new_gene, 0);
        end else begin
          w = pending_results.pop_front();
          if (out_new_gene !== w.gene) note_mismatch("new_gene", out_new_gene, w.gene);
          if (out_difference_sum !== w.dsum)
            note_mismatch("difference_sum", out_difference_sum, w.dsum);
          if (out_generation !== w.gen) note_mismatch("generation", out_generation, w.gen);
          if (out_last_out !== w.last) note_mismatch("last_out", out_last_out, w.last);
        end
      end
      if (in_valid && in_ready) begin
        b.op = op_t'(in_opcode);
        b.own = in_own_gene;
        b.other = in_other_gene;
        b.idx = in_gene_index;
        b.cpt = in_crossover_point;
        b.rsel = in_random_select;
        b.rval = in_random_value;
        b.last = in_last;
        w = apply_gene_op(b);
        if (pin_on) begin
          w.gene = pin_gene;
          w.dsum = pin_sum;
          w.gen = pin_gen;
        end
        pending_results.push_back(w);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MATE_MODE:     sh_mate_mode = mate_mode_t'(cfg_data[1:0]);
          CFG_BOUNDS_MODE:   sh_bounds = cfg_data[1:0];
          CFG_MATE_PARAM:    sh_mate_param = cfg_data[16:0];
          CFG_MUTATE_PROB:   sh_mutate_prob = cfg_data[16:0];
          CFG_MUTATE_AMOUNT: sh_mutate_amount = cfg_data[18:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic add_gene(input op_t op, input int own, input int other, input int idx,
                          input int cpt, input int rsel, input int rval, input int last,
                          input bit pin, input int wgene, input longint wsum,
                          input longint wgen);
    script_row_t row;
    row.kind = ROW_GENE;
    row.beat.op = op;
    row.beat.own = GENE_W'(own);
    row.beat.other = GENE_W'(other);
    row.beat.idx = IDX_W'(idx);
    row.beat.cpt = IDX_W'(cpt);
    row.beat.rsel = RAND_W'(rsel);
    row.beat.rval = RAND_W'(rval);
    row.beat.last = last[0];
    row.reg_index = '0;
    row.reg_value = '0;
    row.pinned = pin;
    row.want.gene = GENE_W'(wgene);
    row.want.dsum = SUM_W'(wsum);
    row.want.gen = SUM_W'(wgen);
    row.want.last = last[0];
    script.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] index, input longint value);
    script_row_t row;
    row.kind = ROW_CFG;
    row.beat.op = OP_MATE;
    row.beat.own = '0;
    row.beat.other = '0;
    row.beat.idx = '0;
    row.beat.cpt = '0;
    row.beat.rsel = '0;
    row.beat.rval = '0;
    row.beat.last = 1'b0;
    row.reg_index = index;
    row.reg_value = CFG_DAT_W'(value);
    row.pinned = 1'b0;
    row.want.gene = '0;
    row.want.dsum = '0;
    row.want.gen = '0;
    row.want.last = 1'b0;
    script.push_back(row);
  endtask

  task automatic drive_gene(input gene_beat_t b, input bit pin, input gene_result_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= b.op;
    in_own_gene <= b.own;
    in_other_gene <= b.other;
    in_gene_index <= b.idx;
    in_crossover_point <= b.cpt;
    in_random_select <= b.rsel;
    in_random_value <= b.rval;
    in_last <= b.last;
    pin_on <= pin;
    pin_gene <= w.gene;
    pin_sum <= w.dsum;
    pin_gen <= w.gen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // hold the input channel until every expected beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DAT_W'(65536);
      2: return CFG_DAT_W'(131071);
      3: return CFG_DAT_W'($urandom_range(0, 131071));
      default: return CFG_DAT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DAT_W'(262144);
      2: return CFG_DAT_W'(524287);
      3: return CFG_DAT_W'($urandom_range(0, 524287));
      default: return CFG_DAT_W'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic program_random_settings();
    logic [CFG_DAT_W-1:0] upper;
    upper = $urandom_range(0, 1) ? CFG_DAT_W'($urandom) : '0;
    write_reg(CFG_MATE_MODE, {upper[CFG_DAT_W-1:2], 2'($urandom_range(0, 3))});
    write_reg(CFG_BOUNDS_MODE, {upper[CFG_DAT_W-1:2], 2'($urandom_range(0, 3))});
    write_reg(CFG_MATE_PARAM, pick_weight());
    write_reg(CFG_MUTATE_PROB, pick_weight());
    write_reg(CFG_MUTATE_AMOUNT, pick_amount());
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'(CFG_MUTATE_AMOUNT + 1 + $urandom_range(0, 2)),
                CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [GENE_W-1:0] pick_gene();
    case ($urandom_range(0, 6))
      0: return GENE_W'($urandom_range(0, 65536));
      1: return GENE_W'(int'($urandom_range(0, 300000)) - 100000);
      2: begin
        case ($urandom_range(0, 3))
          0: return GENE_W'(GENE_TOP);
          1: return GENE_W'(GENE_BOTTOM);
          2: return GENE_W'(GENE_ONE);
          default: return '0;
        endcase
      end
      default: return GENE_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAND_W-1:0] pick_rand16();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return RAND_W'($urandom);
  endfunction

  function automatic gene_beat_t random_beat();
    gene_beat_t b;
    b.op = op_t'($urandom_range(0, 3));
    b.own = pick_gene();
    b.other = pick_gene();
    b.idx = IDX_W'($urandom);
    b.cpt = ($urandom_range(0, 3) == 0) ? b.idx : IDX_W'($urandom);
    b.rsel = pick_rand16();
    b.rval = pick_rand16();
    b.last = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  // genome passes: one opcode per pass, mostly closed by last; some passes are mixed noise
  task automatic run_gene_passes(input int count, input bit pause_midway);
    gene_beat_t b;
    gene_result_t none;
    op_t pass_op;
    int left, len, cpt_pass;
    bit mixed;
    none = '{default: '0};
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 16);
      mixed = ($urandom_range(0, 4) == 0);
      pass_op = op_t'($urandom_range(0, 3));
      cpt_pass = $urandom_range(0, len);
      for (int i = 0; i < len && left > 0; i++) begin
        b = random_beat();
        if (!mixed) begin
          b.op = pass_op;
          b.idx = IDX_W'(i);
          b.cpt = IDX_W'(cpt_pass);
          b.last = (i == len - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
        end
        drive_gene(b, 1'b0, none);
        left--;
        if (pause_midway && left == count / 2) drain_results();
      end
    end
  endtask

  initial begin
    bit cfg_open;
    cfg_open = 1'b0;

    add_gene(OP_MATE, 16384, 49152, 0, 0, 0, 0, 0, 1, 49152, 0, 0);
    add_gene(OP_MATE, 16384, 49152, 0, 4095, 0, 0, 0, 1, 16384, 0, 0);
    add_gene(OP_MATE, 524287, -524288, 4095, 0, 0, 0, 1, 1, 0, 0, 1);
    add_gene(OP_MATE, 524287, -524288, 0, 4095, 0, 0, 0, 1, 65535, 0, 1);
    add_gene(OP_MUT_RESET, 65536, 0, 0, 0, 0, 65535, 0, 1, 65536, 0, 1);
    add_gene(OP_MUT_PERTURB, -1, 0, 0, 0, 65535, 65535, 1, 1, 65535, 0, 2);
    add_gene(OP_DIFF, -524288, 524287, 0, 0, 0, 0, 0, 1, -524288, 1048575, 2);
    add_gene(OP_DIFF, 524287, -524288, 0, 0, 0, 0, 1, 1, 524287, 2097150, 2);
    add_gene(OP_DIFF, 0, 0, 4095, 4095, 65535, 65535, 1, 1, 0, 0, 2);
    add_cfg(CFG_MATE_MODE, MATE_UNIFORM);
    add_cfg(CFG_BOUNDS_MODE, BND_NONE);
    add_cfg(CFG_MATE_PARAM, 131071);
    add_gene(OP_MATE, -524288, 524287, 0, 0, 65535, 0, 0, 1, -524288, 0, 2);
    add_cfg(CFG_MATE_PARAM, 0);
    add_gene(OP_MATE, -524288, 524287, 0, 0, 1, 0, 0, 1, 524287, 0, 2);
    add_gene(OP_MATE, -524288, 524287, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cfg(CFG_MATE_MODE, MATE_BLEND);
    add_cfg(CFG_MATE_PARAM, 131071);
    add_gene(OP_MATE, 100, -524288, 0, 0, 0, 0, 0, 1, -524288, 0, 2);
    add_cfg(CFG_MATE_PARAM, 32768);
    add_gene(OP_MATE, 524287, 524287, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_gene(OP_MATE, -524288, 524287, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cfg(CFG_MATE_MODE, MATE_RANDOM);
    add_cfg(CFG_BOUNDS_MODE, BND_UNUSED);
    add_gene(OP_MATE, -524288, 524287, 0, 0, 0, 65535, 0, 0, 0, 0, 0);
    add_gene(OP_MATE, 524287, -524288, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cfg(CFG_MUTATE_PROB, 131071);
    add_cfg(CFG_MUTATE_AMOUNT, 262144);
    add_gene(OP_MUT_RESET, 0, 0, 0, 0, 65535, 65535, 0, 1, 65535, 0, 2);
    add_gene(OP_MUT_PERTURB, 524287, 0, 0, 0, 65535, 65535, 0, 0, 0, 0, 0);
    add_gene(OP_MUT_PERTURB, -524288, 0, 0, 0, 65535, 0, 0, 1, -524288, 0, 2);
    add_cfg(CFG_BOUNDS_MODE, BND_CLAMP);
    add_gene(OP_MUT_PERTURB, 524287, 0, 0, 0, 65535, 65535, 0, 1, 65536, 0, 2);
    add_gene(OP_MUT_PERTURB, -524288, 0, 0, 0, 65535, 0, 1, 1, 0, 0, 3);
    add_cfg(CFG_MUTATE_AMOUNT, 524287);
    add_gene(OP_MUT_PERTURB, 0, 0, 0, 0, 0, 32768, 0, 0, 0, 0, 0);

    tx_idle_pct = 10;
    rx_idle_pct = 80;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        if (!cfg_open) drain_results();
        write_reg(script[i].reg_index, script[i].reg_value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        drive_gene(script[i].beat, script[i].pinned, script[i].want);
      end
    end
    if (cfg_open) cfg_valid <= 1'b0;

    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 80 : 0;
      rx_idle_pct = (seg < 2) ? 80 : (seg < 4) ? 10 : 0;
      drain_results();
      program_random_settings();
      run_gene_passes(PASS_ITEMS, seg == 1);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
